### hw/rtl/dcglcd_pkg.sv
// Package: panel geometry, controller command codes, request codes and result type.
package dcglcd_pkg;

   localparam int PANEL_COLUMNS = 128;
   localparam int HALF_COLUMNS  = 64;
   localparam int BURST_DEPTH   = 4;

   localparam logic [7:0] CMD_PAGE       = 8'hB8;
   localparam logic [7:0] CMD_COLUMN     = 8'h40;
   localparam logic [7:0] CMD_START_LINE = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h3F;
   localparam logic [7:0] PAGE_MASK      = 8'h07;
   localparam logic [7:0] OFFSET_MASK    = 8'h3F;

   localparam logic CHIP_LEFT  = 1'b0;
   localparam logic CHIP_RIGHT = 1'b1;
   localparam logic RS_CMD     = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef enum logic [1:0] {
      REQ_INIT  = 2'd0,
      REQ_START = 2'd1,
      REQ_CONT  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic       chip_select;
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       error_flag;
      logic       last;
   } rsp_item_type;

   function automatic logic chip_of(input logic [7:0] col);
      return ({1'b0, col} >= 9'(HALF_COLUMNS)) ? CHIP_RIGHT : CHIP_LEFT;
   endfunction

   function automatic logic [7:0] col_cmd(input logic [7:0] col);
      logic [7:0] off;
      off = chip_of(col) ? (col - 8'(HALF_COLUMNS)) : col;
      return CMD_COLUMN | (off & OFFSET_MASK);
   endfunction

   function automatic logic [7:0] page_cmd(input logic [2:0] pg);
      return CMD_PAGE | ({5'd0, pg} & PAGE_MASK);
   endfunction

   function automatic rsp_item_type make_item(input logic chip, input logic rs,
                                              input logic [7:0] byte_val,
                                              input logic err, input logic fin);
      rsp_item_type it;
      it.chip_select = chip;
      it.reg_select  = rs;
      it.bus_byte    = byte_val;
      it.error_flag  = err;
      it.last        = fin;
      return it;
   endfunction

endpackage

### hw/rtl/dcglcd_if.sv
// Valid/ready channel interfaces for write requests and controller transactions.
interface dcglcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [2:0] page;
   logic [7:0] column;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output page, output column,
                   output data_byte, input ready);
   modport sink   (input valid, input req_type, input page, input column,
                   input data_byte, output ready);
endinterface

interface dcglcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_select;
   logic       reg_select;
   logic [7:0] bus_byte;
   logic       error_flag;
   logic       last;

   modport source (output valid, output chip_select, output reg_select, output bus_byte,
                   output error_flag, output last, input ready);
   modport sink   (input valid, input chip_select, input reg_select, input bus_byte,
                   input error_flag, input last, output ready);
endinterface

### hw/rtl/dual_chip_glcd_write_sequencer_top.sv
// Two-controller graphic LCD write sequencer: requests in, controller transactions out.
//
//  channel    dir  handshake            payload
//  req_chan   in   valid/ready          req_type, page, column, data_byte
//  rsp_chan   out  valid/ready          chip_select, reg_select, bus_byte, error_flag, last
//
// A request is decoded in its accept cycle into a burst register of up to four
// transactions; one transaction per cycle moves into the output register while it is free.
// An item yields 1 to 4 transactions, all sent through the single output register;
// some items yield no transaction at all.
// The next request is taken in the cycle its predecessor's final transaction leaves the burst register.
// Synchronous reset closes any run and empties burst and output registers.
module dual_chip_glcd_write_sequencer_top (
   input  logic               clock,
   input  logic               reset,
   dcglcd_req_if.sink         req_chan,
   dcglcd_rsp_if.source       rsp_chan
);

   dcglcd_pkg::rsp_item_type burst_ff [dcglcd_pkg::BURST_DEPTH];
   dcglcd_pkg::rsp_item_type burst_in [dcglcd_pkg::BURST_DEPTH];
   logic [2:0]               burst_cnt_ff, burst_cnt_in;
   dcglcd_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     run_active_ff, run_active_in;
   logic [2:0]               current_page_ff, current_page_in;
   logic [7:0]               current_column_ff, current_column_in;

   logic out_free;
   logic pop;
   logic accept;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (burst_cnt_ff != 3'd0) && out_free;
   assign req_chan.ready = (burst_cnt_ff == 3'd0) || ((burst_cnt_ff == 3'd1) && out_free);
   assign accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [7:0] adv_col;
      logic [8:0] next9;
      logic       chip;
      burst_in          = burst_ff;
      burst_cnt_in      = burst_cnt_ff;
      run_active_in     = run_active_ff;
      current_page_in   = current_page_ff;
      current_column_in = current_column_ff;
      adv_col           = current_column_ff;
      chip              = dcglcd_pkg::CHIP_LEFT;
      next9             = '0;

      if (pop) begin
         for (int i = 0; i < dcglcd_pkg::BURST_DEPTH - 1; i++) begin
            burst_in[i] = burst_ff[i + 1];
         end
         burst_in[dcglcd_pkg::BURST_DEPTH - 1] = '0;
         burst_cnt_in = burst_cnt_ff - 3'd1;
      end

      if (accept) begin
         unique case (dcglcd_pkg::req_code_type'(req_chan.req_type))
            dcglcd_pkg::REQ_INIT: begin
               burst_in[0] = dcglcd_pkg::make_item(dcglcd_pkg::CHIP_LEFT, dcglcd_pkg::RS_CMD,
                                dcglcd_pkg::CMD_START_LINE, 1'b0, 1'b0);
               burst_in[1] = dcglcd_pkg::make_item(dcglcd_pkg::CHIP_RIGHT, dcglcd_pkg::RS_CMD,
                                dcglcd_pkg::CMD_START_LINE, 1'b0, 1'b0);
               burst_in[2] = dcglcd_pkg::make_item(dcglcd_pkg::CHIP_LEFT, dcglcd_pkg::RS_CMD,
                                dcglcd_pkg::CMD_DISPLAY_ON, 1'b0, 1'b0);
               burst_in[3] = dcglcd_pkg::make_item(dcglcd_pkg::CHIP_RIGHT, dcglcd_pkg::RS_CMD,
                                dcglcd_pkg::CMD_DISPLAY_ON, 1'b0, 1'b1);
               burst_cnt_in  = 3'd4;
               run_active_in = 1'b0;
            end
            dcglcd_pkg::REQ_START: begin
               if ({1'b0, req_chan.column} >= 9'(dcglcd_pkg::PANEL_COLUMNS)) begin
                  burst_in[0]   = dcglcd_pkg::make_item(1'b0, 1'b0, 8'd0, 1'b1, 1'b1);
                  burst_cnt_in  = 3'd1;
                  run_active_in = 1'b0;
               end else begin
                  chip        = dcglcd_pkg::chip_of(req_chan.column);
                  burst_in[0] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_CMD,
                                   dcglcd_pkg::page_cmd(req_chan.page), 1'b0, 1'b0);
                  burst_in[1] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_CMD,
                                   dcglcd_pkg::col_cmd(req_chan.column), 1'b0, 1'b0);
                  burst_in[2] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_DATA,
                                   req_chan.data_byte, 1'b0, 1'b1);
                  burst_cnt_in    = 3'd3;
                  current_page_in = req_chan.page;
                  run_active_in   = 1'b1;
                  adv_col         = req_chan.column;
                  next9           = {1'b0, adv_col} + 9'd1;
                  if (next9 >= 9'(dcglcd_pkg::PANEL_COLUMNS)) begin
                     run_active_in     = 1'b0;
                     current_column_in = 8'd0;
                  end else begin
                     current_column_in = next9[7:0];
                  end
               end
            end
            dcglcd_pkg::REQ_CONT: begin
               if (run_active_ff) begin
                  chip = dcglcd_pkg::chip_of(current_column_ff);
                  if ({1'b0, current_column_ff} == 9'(dcglcd_pkg::HALF_COLUMNS)) begin
                     burst_in[0] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_CMD,
                                      dcglcd_pkg::page_cmd(current_page_ff), 1'b0, 1'b0);
                     burst_in[1] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_CMD,
                                      dcglcd_pkg::col_cmd(current_column_ff), 1'b0, 1'b0);
                     burst_in[2] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_DATA,
                                      req_chan.data_byte, 1'b0, 1'b1);
                     burst_cnt_in = 3'd3;
                  end else begin
                     burst_in[0] = dcglcd_pkg::make_item(chip, dcglcd_pkg::RS_DATA,
                                      req_chan.data_byte, 1'b0, 1'b1);
                     burst_cnt_in = 3'd1;
                  end
                  next9 = {1'b0, adv_col} + 9'd1;
                  if (next9 >= 9'(dcglcd_pkg::PANEL_COLUMNS)) begin
                     run_active_in     = 1'b0;
                     current_column_in = 8'd0;
                  end else begin
                     current_column_in = next9[7:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_free) begin
         rsp_valid_in = pop;
         if (pop) begin
            rsp_item_in = burst_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      burst_ff    <= burst_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         burst_cnt_ff      <= 3'd0;
         rsp_valid_ff      <= 1'b0;
         run_active_ff     <= 1'b0;
         current_page_ff   <= 3'd0;
         current_column_ff <= 8'd0;
      end else begin
         burst_cnt_ff      <= burst_cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
         run_active_ff     <= run_active_in;
         current_page_ff   <= current_page_in;
         current_column_ff <= current_column_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.chip_select = rsp_item_ff.chip_select;
   assign rsp_chan.reg_select  = rsp_item_ff.reg_select;
   assign rsp_chan.bus_byte    = rsp_item_ff.bus_byte;
   assign rsp_chan.error_flag  = rsp_item_ff.error_flag;
   assign rsp_chan.last        = rsp_item_ff.last;

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_cnt_ff <= 3'(dcglcd_pkg::BURST_DEPTH))
      else $error("burst count exceeds depth");

   a_column_in_panel: assert property (@(posedge clock) disable iff (reset)
      {1'b0, current_column_ff} < 9'(dcglcd_pkg::PANEL_COLUMNS))
      else $error("run column outside panel");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.error_flag |->
         rsp_item_ff.last && (rsp_item_ff.bus_byte == 8'd0) && !rsp_item_ff.reg_select)
      else $error("malformed error transaction");

   a_bad_start_closes: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.req_type == dcglcd_pkg::REQ_START) &&
         ({1'b0, req_chan.column} >= 9'(dcglcd_pkg::PANEL_COLUMNS))
      |=> !run_active_ff && (burst_cnt_ff == 3'd1))
      else $error("bad start column left a run open");

endmodule
